// ===== design/vdr_pkg.sv =====
// ----------------------------------------------------------------------------
// vdr_pkg
// Shared widths, request and status codes and the control structs of the
// vertex welding block.
// ----------------------------------------------------------------------------
`default_nettype none

package vdr_pkg;

   // Fixed field widths of the request and response channels
   localparam int unsigned TYPE_W   = 2;
   localparam int unsigned COORD_W  = 32;
   localparam int unsigned INDEX_W  = 10;
   localparam int unsigned ID_W     = 10;
   localparam int unsigned STATUS_W = 2;

   // Request codes
   localparam logic [TYPE_W-1:0] REQ_ADD   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_REMAP = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNLOADED = 2'd2;

   // Commands from the sequencer to the point table
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } vdr_pt_ctl_type;

   // Compare result returned by the point table
   typedef struct packed {
      logic valid;
      logic hit;
   } vdr_pt_stat_type;

endpackage

`default_nettype wire

// ===== design/vdr_req_if.sv =====
// ----------------------------------------------------------------------------
// vdr_req_if
// Request channel: valid/ready handshake with the vertex or index request.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdr_req_if;
   logic                               valid;
   logic                               ready;
   logic [vdr_pkg::TYPE_W-1:0]         req_type;
   logic signed [vdr_pkg::COORD_W-1:0] coord_x;
   logic signed [vdr_pkg::COORD_W-1:0] coord_y;
   logic signed [vdr_pkg::COORD_W-1:0] coord_z;
   logic [vdr_pkg::INDEX_W-1:0]        old_index;

   modport source (output valid, req_type, coord_x, coord_y, coord_z, old_index,
                   input ready);
   modport sink   (input valid, req_type, coord_x, coord_y, coord_z, old_index,
                   output ready);
endinterface

`default_nettype wire

// ===== design/vdr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// vdr_rsp_if
// Response channel: valid/ready handshake with the welded id and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface vdr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vdr_pkg::ID_W-1:0]      new_id;
   logic                          is_new;
   logic [vdr_pkg::STATUS_W-1:0]  status;

   modport source (output valid, new_id, is_new, status, input ready);
   modport sink   (input valid, new_id, is_new, status, output ready);
endinterface

`default_nettype wire

// ===== design/vdr_point_table.sv =====
// ----------------------------------------------------------------------------
// vdr_point_table
// Storage of the unique points: one write port, one registered read port,
// and an equality compare of the read data against the probe point.
// ----------------------------------------------------------------------------
`default_nettype none

module vdr_point_table #(
   parameter int unsigned ADDR_W  = 10,
   parameter int unsigned POINT_W = 96
) (
   input  wire                          clock,
   input  wire                          reset,
   input  vdr_pkg::vdr_pt_ctl_type      ctl,
   input  wire [ADDR_W-1:0]             rd_addr,
   input  wire [ADDR_W-1:0]             wr_addr,
   input  wire [POINT_W-1:0]            wr_point,
   input  wire [POINT_W-1:0]            key,
   output vdr_pkg::vdr_pt_stat_type     stat,
   output logic [ADDR_W-1:0]            tag
);

   localparam int unsigned DEPTH = 1 << ADDR_W;

   logic [POINT_W-1:0] mem [DEPTH];
   logic [POINT_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  tag_ff;
   logic               rd_valid_ff;

   // Write new points, read one entry per cycle
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_point;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         tag_ff     <= rd_addr;
      end
   end

   // Track which cycle carries fresh read data
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ctl.rd_en;
      end
   end

   // Compare the read entry against the probe point
   always_comb begin
      stat.valid = rd_valid_ff;
      stat.hit   = (rd_data_ff == key);
      tag        = tag_ff;
   end

endmodule

`default_nettype wire

// ===== design/vertex_dedup_remap_top.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_remap_top
// Exact-position vertex welding with a per-vertex id map for face remapping.
// ----------------------------------------------------------------------------
// One request is in work at a time. An add-vertex request scans the stored
// unique points through the single read port of the point table, one entry
// per cycle, and stops at the first exact match. A remap request reads the
// id map once; clear, unused codes, a full table and a not yet loaded index
// go straight to the response. The response register lets a new request be
// accepted while the previous response still waits. No clearing pass is
// needed after reset: the contents of both memories are only used below the
// vertex and unique counts.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_dedup_remap_top #(
   parameter int unsigned MAX_VERTICES = 1024,
   parameter int unsigned COORD_BITS   = 32
) (
   input  wire       clock,
   input  wire       reset,
   vdr_req_if.sink   req,
   vdr_rsp_if.source rsp
);

   localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
   localparam int unsigned XW = (CW > vdr_pkg::INDEX_W) ? CW : vdr_pkg::INDEX_W;
   localparam int unsigned SB = (COORD_BITS < vdr_pkg::COORD_W) ? COORD_BITS
                                                                : vdr_pkg::COORD_W;
   localparam int unsigned PW = 3 * SB;
   localparam int unsigned DEPTH = 1 << AW;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_COMMIT = 6'b000100,
      ST_LOOK   = 6'b001000,
      ST_LDATA  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CW-1:0]                   vcount_ff, vcount_in;
   logic [CW-1:0]                   ucount_ff, ucount_in;
   logic [CW-1:0]                   scan_ff, scan_in;
   logic [PW-1:0]                   key_ff;
   logic [AW-1:0]                   idx_ff;
   logic                            hit_ff, hit_in;
   logic [AW-1:0]                   hid_ff, hid_in;
   logic [vdr_pkg::ID_W-1:0]        res_id_ff, res_id_in;
   logic                            res_new_ff, res_new_in;
   logic [vdr_pkg::STATUS_W-1:0]    res_st_ff, res_st_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [vdr_pkg::ID_W-1:0]        rsp_id_ff;
   logic                            rsp_new_ff;
   logic [vdr_pkg::STATUS_W-1:0]    rsp_st_ff;

   logic [AW-1:0]                   id_map [DEPTH];
   logic [AW-1:0]                   map_q_ff;
   logic                            map_we;
   logic [AW-1:0]                   map_wdata;

   vdr_pkg::vdr_pt_ctl_type         pt_ctl;
   vdr_pkg::vdr_pt_stat_type        pt_stat;
   logic [AW-1:0]                   pt_tag;

   logic                            accept;
   logic                            load_rsp;
   logic                            commit_full;

   assign accept   = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);
   assign commit_full = !hit_ff && (ucount_ff >= CW'(MAX_VERTICES));

   // Unique point storage and compare
   vdr_point_table #(
      .ADDR_W  (AW),
      .POINT_W (PW)
   ) u_points (
      .clock    (clock),
      .reset    (reset),
      .ctl      (pt_ctl),
      .rd_addr  (scan_ff[AW-1:0]),
      .wr_addr  (ucount_ff[AW-1:0]),
      .wr_point (key_ff),
      .key      (key_ff),
      .stat     (pt_stat),
      .tag      (pt_tag)
   );

   // Id map: write on commit, read the remap index every cycle
   assign map_we    = (state_ff == ST_COMMIT) && !commit_full;
   assign map_wdata = hit_ff ? hid_ff : ucount_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (map_we) begin
         id_map[vcount_ff[AW-1:0]] <= map_wdata;
      end
      map_q_ff <= id_map[idx_ff];
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      ucount_in    = ucount_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      hid_in       = hid_ff;
      res_id_in    = res_id_ff;
      res_new_in   = res_new_ff;
      res_st_in    = res_st_ff;
      pt_ctl.rd_en = 1'b0;
      pt_ctl.wr_en = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            res_id_in  = '0;
            res_new_in = 1'b0;
            res_st_in  = vdr_pkg::ST_OK;
            if (accept) begin
               unique case (req.req_type)
                  vdr_pkg::REQ_ADD: begin
                     if (vcount_ff >= CW'(MAX_VERTICES)) begin
                        res_st_in = vdr_pkg::ST_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        scan_in  = '0;
                        hit_in   = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  vdr_pkg::REQ_REMAP: begin
                     if (XW'(req.old_index) >= XW'(vcount_ff)) begin
                        res_st_in = vdr_pkg::ST_UNLOADED;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_LOOK;
                     end
                  end
                  vdr_pkg::REQ_CLEAR: begin
                     vcount_in = '0;
                     ucount_in = '0;
                     state_in  = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Stop on the first match, else issue the next read
            if (pt_stat.valid && pt_stat.hit) begin
               hit_in   = 1'b1;
               hid_in   = pt_tag;
               state_in = ST_COMMIT;
            end else if (scan_ff < ucount_ff) begin
               pt_ctl.rd_en = 1'b1;
               scan_in      = scan_ff + 1'b1;
            end else if (!pt_stat.valid) begin
               hit_in   = 1'b0;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (commit_full) begin
               res_st_in = vdr_pkg::ST_FULL;
            end else begin
               if (!hit_ff) begin
                  pt_ctl.wr_en = 1'b1;
                  ucount_in    = ucount_ff + 1'b1;
               end
               vcount_in  = vcount_ff + 1'b1;
               res_id_in  = vdr_pkg::ID_W'(map_wdata);
               res_new_in = !hit_ff;
            end
            state_in = ST_DONE;
         end
         ST_LOOK: begin
            state_in = ST_LDATA;
         end
         ST_LDATA: begin
            res_id_in = vdr_pkg::ID_W'(map_q_ff);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on load, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= '0;
         ucount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         ucount_ff    <= ucount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      hit_ff     <= hit_in;
      hid_ff     <= hid_in;
      res_id_ff  <= res_id_in;
      res_new_ff <= res_new_in;
      res_st_ff  <= res_st_in;
      if (accept) begin
         key_ff <= {req.coord_x[SB-1:0], req.coord_y[SB-1:0], req.coord_z[SB-1:0]};
         idx_ff <= AW'(req.old_index);
      end
      if (load_rsp) begin
         rsp_id_ff  <= res_id_ff;
         rsp_new_ff <= res_new_ff;
         rsp_st_ff  <= res_st_ff;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.new_id = rsp_id_ff;
   assign rsp.is_new = rsp_new_ff;
   assign rsp.status = rsp_st_ff;

endmodule

`default_nettype wire
